// ===== rtl/core/length_prefixed_string_array_parser_unit_assert.svh =====
// Assertion macros shared by the string-array deframer RTL.
`ifndef LENGTH_PREFIXED_STRING_ARRAY_PARSER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_STRING_ARRAY_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LPSAP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
`define LPSAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define LPSAP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LPSAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lpsap_pkg.sv =====
// Shared types and constants of the string-array deframer.
`timescale 1ns / 1ps
package lpsap_pkg;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_COUNT     = 3'd1;
    localparam logic [2:0] PH_INDICATOR = 3'd2;
    localparam logic [2:0] PH_LENGTH    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD   = 3'd4;
    localparam logic [2:0] PH_DONE      = 3'd5;

    localparam logic [7:0] ONE_BYTE_MAX  = 8'd245;
    localparam logic [7:0] TWO_BYTE_MARK = 8'd246;
    localparam logic [7:0] NUL_CHAR      = 8'd0;

    localparam logic ERR_NONE     = 1'b0;
    localparam logic ERR_NEG_LEN  = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        has_char;
        logic [7:0]  char_value;
        logic        ends_element;
        logic        ends_array;
        logic [31:0] element_number;
        logic        error_code;
    } t_result;

endpackage

// ===== rtl/core/length_prefixed_string_array_parser_unit.sv =====
// Top level of the length-prefixed string-array deframer.
// The block takes one blob byte per beat and gives at most one result beat per byte: a
// character of the current element, an end-of-element mark (possibly with the last
// character), or the end of an empty array. Throughput is one byte per clock while the output
// is not held by i_m_axis_tready; a byte's result passes through the input register, the parse
// logic in the byte-state update, and the output register. A beat with tuser set starts a new
// blob; bytes before any blob start or after the array is complete give no result. Negative
// lengths close the element at once with the error flag set.
`timescale 1ns / 1ps
`include "length_prefixed_string_array_parser_unit_assert.svh"
module length_prefixed_string_array_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] blob_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] char_value, [39:8] element_number
    output logic [2:0]  o_m_axis_tuser,   // [0] has_char, [1] ends_element, [2] error_code
    output logic        o_m_axis_tlast    // ends_array
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;
    logic               r_out_valid;
    lpsap_pkg::t_result r_out;
    lpsap_pkg::t_result w_res;
    logic               w_adv;
    logic               w_fire;

    // The parse stage moves whenever the result register is free or being drained.
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser;
        end
    end

    lpsap_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_data_byte  (r_in_byte),
        .i_blob_start (r_in_start),
        .o_result     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.element_number, r_out.char_value};
    assign o_m_axis_tuser  = {r_out.error_code, r_out.ends_element, r_out.has_char};
    assign o_m_axis_tlast  = r_out.ends_array;

    `LPSAP_ASSERT_IMPLY(a_char_not_nul, i_clk, i_rst_n, r_out_valid && r_out.has_char, r_out.char_value != lpsap_pkg::NUL_CHAR)
    `LPSAP_ASSERT_IMPLY(a_err_closes, i_clk, i_rst_n, r_out_valid && r_out.error_code, r_out.ends_element && !r_out.has_char)
    `LPSAP_ASSERT_IMPLY(a_empty_array, i_clk, i_rst_n, r_out_valid && r_out.ends_array && !r_out.ends_element, r_out.element_number == 32'd0 && !r_out.has_char)
    `LPSAP_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in_byte) && $stable(r_in_start))

endmodule

// ===== rtl/core/lpsap_parser.sv =====
// Per-byte parse state and the result of one blob byte.
`timescale 1ns / 1ps
module lpsap_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_data_byte,
    input  logic               i_blob_start,
    output lpsap_pkg::t_result o_result
);

    logic [2:0]  r_phase,  n_phase;
    logic [1:0]  r_fbi,    n_fbi;
    logic [31:0] r_rem_el, n_rem_el;
    logic [31:0] r_len,    n_len;
    logic        r_short,  n_short;
    logic [31:0] r_rem_pay, n_rem_pay;
    logic        r_nul,    n_nul;
    logic [31:0] r_cur,    n_cur;

    always_comb begin
        logic [7:0]  b;
        logic        do_close;
        logic        close_hc;
        logic        close_err;
        logic        sp_go;
        logic [31:0] sp_len;
        logic        sp_err;
        logic        is_char;
        logic        last;
        logic [31:0] rem_dec;
        logic [31:0] pay_dec;

        b         = i_data_byte;
        do_close  = 1'b0;
        close_hc  = 1'b0;
        close_err = lpsap_pkg::ERR_NONE;
        sp_go     = 1'b0;
        sp_len    = '0;
        sp_err    = lpsap_pkg::ERR_NONE;
        is_char   = 1'b0;
        pay_dec   = '0;

        n_phase   = r_phase;
        n_fbi     = r_fbi;
        n_rem_el  = r_rem_el;
        n_len     = r_len;
        n_short   = r_short;
        n_rem_pay = r_rem_pay;
        n_nul     = r_nul;
        n_cur     = r_cur;

        o_result                = '0;
        o_result.element_number = r_cur;

        // A blob start abandons whatever was in progress.
        if (i_blob_start) begin
            n_phase   = lpsap_pkg::PH_COUNT;
            n_fbi     = '0;
            n_rem_el  = '0;
            n_len     = '0;
            n_short   = 1'b0;
            n_rem_pay = '0;
            n_nul     = 1'b0;
            n_cur     = '0;
            o_result.element_number = '0;
        end

        case (n_phase)
            lpsap_pkg::PH_COUNT: begin
                n_rem_el = n_rem_el | ({24'd0, b} << {n_fbi, 3'b000});
                if (n_fbi == 2'd3) begin
                    n_fbi = '0;
                    if (n_rem_el == '0) begin
                        n_phase = lpsap_pkg::PH_DONE;
                        o_result.valid      = 1'b1;
                        o_result.ends_array = 1'b1;
                    end else begin
                        n_phase = lpsap_pkg::PH_INDICATOR;
                    end
                end else begin
                    n_fbi = n_fbi + 2'd1;
                end
            end
            lpsap_pkg::PH_INDICATOR: begin
                if (b <= lpsap_pkg::ONE_BYTE_MAX) begin
                    sp_go  = 1'b1;
                    sp_len = {24'd0, b};
                end else begin
                    n_short = (b == lpsap_pkg::TWO_BYTE_MARK);
                    n_len   = '0;
                    n_fbi   = '0;
                    n_phase = lpsap_pkg::PH_LENGTH;
                end
            end
            lpsap_pkg::PH_LENGTH: begin
                n_len = n_len | ({24'd0, b} << {n_fbi, 3'b000});
                if ((n_short && n_fbi == 2'd1) || n_fbi == 2'd3) begin
                    n_fbi = '0;
                    sp_go = 1'b1;
                    if (n_short ? n_len[15] : n_len[31]) begin
                        sp_err = lpsap_pkg::ERR_NEG_LEN;
                    end else begin
                        sp_len = n_short ? {17'd0, n_len[14:0]} : n_len;
                    end
                end else begin
                    n_fbi = n_fbi + 2'd1;
                end
            end
            lpsap_pkg::PH_PAYLOAD: begin
                is_char = !n_nul && (b != lpsap_pkg::NUL_CHAR);
                if (b == lpsap_pkg::NUL_CHAR) begin
                    n_nul = 1'b1;
                end
                pay_dec   = n_rem_pay - 32'd1;
                n_rem_pay = pay_dec;
                if (pay_dec == '0) begin
                    do_close = 1'b1;
                    close_hc = is_char;
                end else if (is_char) begin
                    o_result.valid      = 1'b1;
                    o_result.has_char   = 1'b1;
                    o_result.char_value = b;
                end
            end
            default: begin
            end
        endcase

        if (sp_go) begin
            if (sp_len == '0) begin
                do_close  = 1'b1;
                close_err = sp_err;
            end else begin
                n_rem_pay = sp_len;
                n_nul     = 1'b0;
                n_phase   = lpsap_pkg::PH_PAYLOAD;
            end
        end

        rem_dec = n_rem_el - 32'd1;
        last    = (rem_dec == '0);
        if (do_close) begin
            n_rem_el = rem_dec;
            o_result.valid          = 1'b1;
            o_result.has_char       = close_hc;
            o_result.char_value     = close_hc ? b : 8'd0;
            o_result.ends_element   = 1'b1;
            o_result.ends_array     = last;
            o_result.element_number = n_cur;
            o_result.error_code     = close_err;
            if (last) begin
                n_phase = lpsap_pkg::PH_DONE;
            end else begin
                n_cur   = n_cur + 32'd1;
                n_phase = lpsap_pkg::PH_INDICATOR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lpsap_pkg::PH_IDLE;
            r_fbi     <= '0;
            r_rem_el  <= '0;
            r_len     <= '0;
            r_short   <= 1'b0;
            r_rem_pay <= '0;
            r_nul     <= 1'b0;
            r_cur     <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_fbi     <= n_fbi;
            r_rem_el  <= n_rem_el;
            r_len     <= n_len;
            r_short   <= n_short;
            r_rem_pay <= n_rem_pay;
            r_nul     <= n_nul;
            r_cur     <= n_cur;
        end
    end

endmodule
